/* rtl/dtc_pkg.sv */
package dtc_pkg;

   // Command codes carried by each request.
   typedef enum logic [1:0] {
      CMD_WRITE_NODE    = 2'd0,
      CMD_WRITE_FEATURE = 2'd1,
      CMD_WRITE_LEAF    = 2'd2,
      CMD_CLASSIFY      = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASSES_IN_USE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DEPTH      = 1'd1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [4:0] CLASSES_RESET   = 5'd16;
   localparam logic [7:0] MAX_DEPTH_RESET = 8'd16;

   // Sequencer states of the tree walk.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NODE,
      ST_FEAT,
      ST_WREAD,
      ST_OUT
   } state_type;

   // One node table entry.
   typedef struct packed {
      logic               leaf;
      logic [5:0]         feat;
      logic signed [15:0] thr;
      logic [7:0]         left;
      logic [7:0]         right;
   } node_entry_type;

endpackage

/* rtl/dtc_req_if.sv */
interface dtc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  node_index;
   logic        leaf_flag;
   logic [5:0]  split_feature;
   logic signed [15:0] split_threshold;
   logic [7:0]  left_index;
   logic [7:0]  right_index;
   logic [5:0]  feature_number;
   logic signed [15:0] feature_value;
   logic [3:0]  bin_class;
   logic [31:0] bin_weight;

   modport source (
      output valid, command, node_index, leaf_flag, split_feature, split_threshold,
             left_index, right_index, feature_number, feature_value, bin_class,
             bin_weight,
      input  ready
   );
   modport sink (
      input  valid, command, node_index, leaf_flag, split_feature, split_threshold,
             left_index, right_index, feature_number, feature_value, bin_class,
             bin_weight,
      output ready
   );
endinterface

/* rtl/dtc_rsp_if.sv */
interface dtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  class_number;
   logic [31:0] class_weight;
   logic [7:0]  leaf_reached;
   logic        depth_fault;
   logic        last;

   modport source (
      output valid, class_number, class_weight, leaf_reached, depth_fault, last,
      input  ready
   );
   modport sink (
      input  valid, class_number, class_weight, leaf_reached, depth_fault, last,
      output ready
   );
endinterface

/* rtl/dtc_csr_if.sv */
interface dtc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dtc_pkg::CSR_INDEX_W-1:0] index;
   logic [dtc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/decision_tree_classifier_top.sv */
// Decision-tree inference engine.
// Requests arrive on req_ch with a command: write a node entry, write one
// sample feature, write one leaf weight, or classify. The three write
// commands produce no response. Classify walks the tree from node 0 and then
// sends one response per class in use on rsp_ch, in class order, with last
// set on the final one.
// Classify accepts the request and fetches the root, then for each node
// visited does a node fetch, then a feature fetch and compare through the
// single comparator, then for each class a weight fetch and an output load.
// The node and feature memories each have one registered read port.
// req_ch.ready is low during reset and while a classification is in progress.
// A walk that is still on an inner node after max_depth steps stops there;
// its responses carry depth_fault set and zero weights.
// Configuration is written on csr_ch, ready whenever reset is low; the user
// must write it only while idle. Reset (synchronous, active high) returns the
// sequencer to idle, drops any pending response and restores classes_in_use
// to 16 and max_depth to 16. Memory contents are not cleared. If the receiver
// stalls, the response register holds its value and the sequencer waits.
module decision_tree_classifier_top #(
   parameter int NODES    = 256,
   parameter int FEATURES = 64,
   parameter int CLASSES  = 16
) (
   input  logic        clock,
   input  logic        reset,
   dtc_req_if.sink     req_ch,
   dtc_rsp_if.source   rsp_ch,
   dtc_csr_if.sink     csr_ch
);

   // Node indexes and feature numbers are 8 and 6 bits wide on the ports, and
   // at most 16 classes are reported, so storage never goes beyond that.
   localparam int NODE_DEPTH  = (NODES < 256) ? NODES : 256;
   localparam int FEAT_DEPTH  = (FEATURES < 64) ? FEATURES : 64;
   localparam int CLASS_DEPTH = (CLASSES < 16) ? CLASSES : 16;
   localparam int NODE_AW     = $clog2(NODE_DEPTH);
   localparam int FEAT_AW     = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int CLASS_AW    = $clog2(CLASS_DEPTH);
   localparam int WGT_DEPTH   = NODE_DEPTH * (2 ** CLASS_AW);

   // Storage.
   dtc_pkg::node_entry_type node_mem [NODE_DEPTH];
   logic signed [15:0]      feat_mem [FEAT_DEPTH];
   logic [31:0]             wgt_mem  [WGT_DEPTH];

   // Sequencer and registers.
   dtc_pkg::state_type state_ff, state_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  steps_ff, steps_in;
   logic [3:0]  k_ff, k_in;
   logic [4:0]  count_ff, count_in;
   logic        fault_ff, fault_in;
   logic [4:0]  classes_ff;
   logic [7:0]  depth_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  class_ff, class_in;
   logic [31:0] weight_ff, weight_in;
   logic [7:0]  leaf_ff, leaf_in;
   logic        dfault_ff, dfault_in;
   logic        last_ff, last_in;

   // Registered memory read data.
   dtc_pkg::node_entry_type node_rd_ff;
   logic                    node_oob_ff;
   logic signed [15:0]      feat_rd_ff;
   logic                    feat_oob_ff;
   logic [31:0]             wgt_rd_ff;

   // Read controls.
   logic        node_rd_en;
   logic [7:0]  node_rd_addr;
   logic        feat_rd_en;
   logic        wgt_rd_en;

   dtc_pkg::node_entry_type node_q;
   logic signed [15:0]      feat_q;
   logic                    take_right;
   logic                    req_fire;
   logic [4:0]              count_clamped;
   logic                    is_last;

   assign req_fire = req_ch.valid && req_ch.ready;

   // A node past the end of the table reads as an inner node with all fields
   // zero, and a feature past the end of the sample reads as zero.
   assign node_q     = node_oob_ff ? '0 : node_rd_ff;
   assign feat_q     = feat_oob_ff ? '0 : feat_rd_ff;
   assign take_right = node_q.thr < feat_q;

   assign count_clamped = (classes_ff == 5'd0) ? 5'd1 :
                          (classes_ff > 5'(CLASS_DEPTH)) ? 5'(CLASS_DEPTH) : classes_ff;
   assign is_last = (({1'b0, k_ff} + 5'd1) == count_ff);

   // Loads from the request channel. Requests are only accepted while idle,
   // so they never collide with the reads of a walk.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         case (req_ch.command)
            dtc_pkg::CMD_WRITE_NODE: begin
               if ({1'b0, req_ch.node_index} < 9'(NODE_DEPTH)) begin
                  node_mem[req_ch.node_index[NODE_AW-1:0]] <= '{
                     leaf:  req_ch.leaf_flag,
                     feat:  req_ch.split_feature,
                     thr:   req_ch.split_threshold,
                     left:  req_ch.left_index,
                     right: req_ch.right_index
                  };
               end
            end
            dtc_pkg::CMD_WRITE_FEATURE: begin
               if ({1'b0, req_ch.feature_number} < 7'(FEAT_DEPTH)) begin
                  feat_mem[req_ch.feature_number[FEAT_AW-1:0]] <= req_ch.feature_value;
               end
            end
            dtc_pkg::CMD_WRITE_LEAF: begin
               if (({1'b0, req_ch.node_index} < 9'(NODE_DEPTH)) &&
                   ({1'b0, req_ch.bin_class} < 5'(CLASS_DEPTH))) begin
                  wgt_mem[{req_ch.node_index[NODE_AW-1:0],
                           req_ch.bin_class[CLASS_AW-1:0]}] <= req_ch.bin_weight;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Memory reads, one registered port each.
   always_ff @(posedge clock) begin
      if (node_rd_en) begin
         node_rd_ff  <= node_mem[node_rd_addr[NODE_AW-1:0]];
         node_oob_ff <= ({1'b0, node_rd_addr} >= 9'(NODE_DEPTH));
      end
      if (feat_rd_en) begin
         feat_rd_ff  <= feat_mem[node_q.feat[FEAT_AW-1:0]];
         feat_oob_ff <= ({1'b0, node_q.feat} >= 7'(FEAT_DEPTH));
      end
      if (wgt_rd_en) begin
         wgt_rd_ff <= wgt_mem[{cur_ff[NODE_AW-1:0], k_ff[CLASS_AW-1:0]}];
      end
   end

   // Configuration registers. A write is only taken outside reset.
   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_ff <= dtc_pkg::CLASSES_RESET;
         depth_ff   <= dtc_pkg::MAX_DEPTH_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            dtc_pkg::CSR_CLASSES_IN_USE: classes_ff <= csr_ch.data[4:0];
            dtc_pkg::CSR_MAX_DEPTH:      depth_ff   <= csr_ch.data[7:0];
            default: begin
            end
         endcase
      end
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk context and response payload need no reset.
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      k_ff      <= k_in;
      count_ff  <= count_in;
      fault_ff  <= fault_in;
      class_ff  <= class_in;
      weight_ff <= weight_in;
      leaf_ff   <= leaf_in;
      dfault_ff <= dfault_in;
      last_ff   <= last_in;
   end

   // Sequencer: next state, walk context and read controls.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      fault_in     = fault_ff;
      class_in     = class_ff;
      weight_in    = weight_ff;
      leaf_in      = leaf_ff;
      dfault_in    = dfault_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      node_rd_en   = 1'b0;
      node_rd_addr = cur_ff;
      feat_rd_en   = 1'b0;
      wgt_rd_en    = 1'b0;
      req_ch.ready = 1'b0;

      case (state_ff)
         dtc_pkg::ST_IDLE: begin
            req_ch.ready = !reset;
            if (req_ch.valid && (req_ch.command == dtc_pkg::CMD_CLASSIFY)) begin
               cur_in       = 8'd0;
               steps_in     = 8'd0;
               fault_in     = 1'b0;
               k_in         = 4'd0;
               count_in     = count_clamped;
               node_rd_en   = 1'b1;
               node_rd_addr = 8'd0;
               state_in     = dtc_pkg::ST_NODE;
            end
         end
         dtc_pkg::ST_NODE: begin
            if (node_q.leaf) begin
               state_in = dtc_pkg::ST_WREAD;
            end else if (steps_ff >= depth_ff) begin
               fault_in = 1'b1;
               state_in = dtc_pkg::ST_WREAD;
            end else begin
               feat_rd_en = 1'b1;
               state_in   = dtc_pkg::ST_FEAT;
            end
         end
         dtc_pkg::ST_FEAT: begin
            cur_in       = take_right ? node_q.right : node_q.left;
            steps_in     = steps_ff + 8'd1;
            node_rd_en   = 1'b1;
            node_rd_addr = cur_in;
            state_in     = dtc_pkg::ST_NODE;
         end
         dtc_pkg::ST_WREAD: begin
            wgt_rd_en = 1'b1;
            state_in  = dtc_pkg::ST_OUT;
         end
         dtc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               class_in     = k_ff;
               weight_in    = fault_ff ? 32'd0 : wgt_rd_ff;
               leaf_in      = cur_ff;
               dfault_in    = fault_ff;
               last_in      = is_last;
               k_in         = k_ff + 4'd1;
               state_in     = is_last ? dtc_pkg::ST_IDLE : dtc_pkg::ST_WREAD;
            end
         end
         default: begin
            state_in = dtc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.class_number = class_ff;
   assign rsp_ch.class_weight = weight_ff;
   assign rsp_ch.leaf_reached = leaf_ff;
   assign rsp_ch.depth_fault  = dfault_ff;
   assign rsp_ch.last         = last_ff;

endmodule
